// File: rtl/core/uuid_text_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// uuid text parser assertion macros
// shared concurrent assertion shorthands for the parser rtl
// ----------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_UNIT_DEFINES_SVH
`define UUID_TEXT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define UUTP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define UUTP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/uutp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uutp_pkg
// types and constants shared by the uuid text parser modules
// ----------------------------------------------------------------------------
package uutp_pkg;

    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int HALF_W      = 64;
    localparam int BYTE_CNT_W  = 5;
    localparam int HYPH_CNT_W  = 3;
    localparam int OUT_FIELD_W = STATUS_W + 2 * HALF_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [BYTE_CNT_W-1:0] UUID_BYTES  = 5'd16;
    localparam logic [BYTE_CNT_W-1:0] HALF_BYTES  = 5'd8;
    localparam logic [HYPH_CNT_W-1:0] MAX_HYPHENS = 3'd4;

    localparam logic [CHAR_W-1:0] CHR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHR_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UF     = 8'h46;
    localparam logic [CHAR_W-1:0] CHR_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LF     = 8'h66;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HYPHENS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LONE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_HYPH_CNT  = 3'd6;

    typedef struct packed {
        logic       is_term;
        logic       is_hyphen;
        logic       is_hex;
        logic [3:0] nibble;
    } t_char_class;

    typedef struct packed {
        logic [HALF_W-1:0]   uuid_low;
        logic [HALF_W-1:0]   uuid_high;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// File: rtl/core/uutp_char_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uutp_char_class
// sorts one character into terminator, hyphen or hex digit with its value
// ----------------------------------------------------------------------------
module uutp_char_class (
    input  logic [uutp_pkg::CHAR_W-1:0] i_char,
    output uutp_pkg::t_char_class       o_class
);
    import uutp_pkg::*;

    logic [CHAR_W-1:0] w_off;

    always_comb begin
        o_class           = '0;
        o_class.is_term   = (i_char == CHR_NUL);
        o_class.is_hyphen = (i_char == CHR_HYPHEN);
        w_off             = '0;
        case (i_char) inside
            [CHR_0:CHR_9]: begin
                o_class.is_hex = 1'b1;
                w_off          = i_char - CHR_0;
            end
            [CHR_LA:CHR_LF]: begin
                o_class.is_hex = 1'b1;
                w_off          = i_char - CHR_LA + 8'd10;
            end
            [CHR_UA:CHR_UF]: begin
                o_class.is_hex = 1'b1;
                w_off          = i_char - CHR_UA + 8'd10;
            end
            default: begin
                o_class.is_hex = 1'b0;
            end
        endcase
        o_class.nibble = w_off[3:0];
    end

endmodule

// File: rtl/core/uutp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uutp_parse_core
// per-string parse state, byte assembly and first-error latch
// ----------------------------------------------------------------------------
`include "uuid_text_parser_unit_defines.svh"

module uutp_parse_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [uutp_pkg::CHAR_W-1:0] i_char,
    output logic                        o_term,
    output uutp_pkg::t_result           o_result
);
    import uutp_pkg::*;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_HYPHEN = 2'd1;
    localparam logic [1:0] PH_HIGH   = 2'd2;

    t_char_class w_cls;

    logic [1:0]            r_phase,      n_phase;
    logic [BYTE_CNT_W-1:0] r_byte_count, n_byte_count;
    logic [HYPH_CNT_W-1:0] r_hyph_count, n_hyph_count;
    logic [3:0]            r_high_nib,   n_high_nib;
    logic [HALF_W-1:0]     r_val_upper,  n_val_upper;
    logic [HALF_W-1:0]     r_val_lower,  n_val_lower;
    logic [STATUS_W-1:0]   r_status,     n_status;
    logic                  r_decided,    n_decided;

    logic [STATUS_W-1:0]   w_fin_status;
    logic [HYPH_CNT_W-1:0] w_hyph_inc;
    logic [BYTE_CNT_W-1:0] w_byte_inc;
    logic [7:0]            w_byte;

    uutp_char_class u_class (
        .i_char  (i_char),
        .o_class (w_cls)
    );

    assign o_term     = w_cls.is_term;
    assign w_hyph_inc = r_hyph_count + 3'd1;
    assign w_byte_inc = r_byte_count + 5'd1;
    assign w_byte     = {r_high_nib, w_cls.nibble};

    // status reported at the terminator
    always_comb begin
        if (r_decided) begin
            w_fin_status = r_status;
        end else begin
            unique case (r_phase)
                PH_HYPHEN: w_fin_status = ST_BAD_CHAR;
                PH_HIGH:   w_fin_status = ST_LONE;
                default: begin
                    if (r_byte_count == '0 && r_hyph_count == '0) begin
                        w_fin_status = ST_EMPTY;
                    end else begin
                        w_fin_status = ST_SHORT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_result.status    = w_fin_status;
        o_result.uuid_high = (w_fin_status == ST_OK) ? r_val_upper : '0;
        o_result.uuid_low  = (w_fin_status == ST_OK) ? r_val_lower : '0;
    end

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_hyph_count = r_hyph_count;
        n_high_nib   = r_high_nib;
        n_val_upper  = r_val_upper;
        n_val_lower  = r_val_lower;
        n_status     = r_status;
        n_decided    = r_decided;
        if (i_step) begin
            if (w_cls.is_term) begin
                n_phase      = PH_START;
                n_byte_count = '0;
                n_hyph_count = '0;
                n_high_nib   = '0;
                n_status     = ST_OK;
                n_decided    = 1'b0;
            end else if (!r_decided) begin
                if (r_phase == PH_START && w_cls.is_hyphen) begin
                    n_hyph_count = w_hyph_inc;
                    if (w_hyph_inc > MAX_HYPHENS) begin
                        n_status  = ST_HYPHENS;
                        n_decided = 1'b1;
                    end else begin
                        n_phase = PH_HYPHEN;
                    end
                end else if (r_phase != PH_HIGH) begin
                    if (!w_cls.is_hex) begin
                        n_status  = ST_BAD_CHAR;
                        n_decided = 1'b1;
                    end else begin
                        n_high_nib = w_cls.nibble;
                        n_phase    = PH_HIGH;
                    end
                end else if (!w_cls.is_hex) begin
                    n_status  = ST_LONE;
                    n_decided = 1'b1;
                end else begin
                    if (r_byte_count < HALF_BYTES) begin
                        n_val_upper = {r_val_upper[HALF_W-9:0], w_byte};
                    end else begin
                        n_val_lower = {r_val_lower[HALF_W-9:0], w_byte};
                    end
                    n_byte_count = w_byte_inc;
                    n_phase      = PH_START;
                    if (w_byte_inc >= UUID_BYTES) begin
                        n_decided = 1'b1;
                        if (r_hyph_count == '0 || r_hyph_count == MAX_HYPHENS) begin
                            n_status = ST_OK;
                        end else begin
                            n_status = ST_HYPH_CNT;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_byte_count <= '0;
            r_hyph_count <= '0;
            r_high_nib   <= '0;
            r_status     <= ST_OK;
            r_decided    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_hyph_count <= n_hyph_count;
            r_high_nib   <= n_high_nib;
            r_status     <= n_status;
            r_decided    <= n_decided;
        end
    end

    // value words need no reset: an ok result has shifted all 16 bytes in
    always_ff @(posedge i_clk) begin
        r_val_upper <= n_val_upper;
        r_val_lower <= n_val_lower;
    end

    `UUTP_ASSERT_IMP(a_ok_full, i_clk, i_rst_n,
        i_step && w_cls.is_term && w_fin_status == ST_OK,
        r_decided && r_byte_count == UUID_BYTES, "ok result without sixteen bytes")
    `UUTP_ASSERT_IMP(a_undecided_short, i_clk, i_rst_n,
        !r_decided, r_byte_count < UUID_BYTES && r_hyph_count <= MAX_HYPHENS,
        "undecided string past its limits")
    `UUTP_ASSERT_NXT(a_term_clears, i_clk, i_rst_n,
        i_step && w_cls.is_term,
        r_phase == PH_START && r_byte_count == '0 && r_hyph_count == '0 && !r_decided,
        "parse state not cleared after terminator")
    `UUTP_ASSERT_NXT(a_decided_holds, i_clk, i_rst_n,
        r_decided && !(i_step && w_cls.is_term),
        r_decided && $stable(r_status), "latched status changed before terminator")

endmodule

// File: rtl/core/uuid_text_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuid_text_parser_unit
// streaming uuid text parser, one character per transaction
// ----------------------------------------------------------------------------
// Takes one character per clock and returns one result transaction per
// string, when the zero terminator arrives. A character is held in an input
// register, goes from there through the parse core's state update, and
// a terminator's result lands in the output register. Sustained rate is one
// character per cycle, set by the state update of the parse core; the input
// only stalls when a terminator meets an output register that is still full.
// Result tdata holds status, then uuid_high, then uuid_low; both uuid words
// are zero unless status is ok.
// ----------------------------------------------------------------------------
`include "uuid_text_parser_unit_defines.svh"

module uuid_text_parser_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // char_in [7:0]
    input  logic [uutp_pkg::CHAR_W-1:0]    i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status [2:0], uuid_high [66:3], uuid_low [130:67], zero [135:131]
    output logic [uutp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import uutp_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_out_valid;
    t_result           r_out_res;

    logic    w_term;
    logic    w_step;
    logic    w_out_free;
    logic    w_emit;
    t_result w_result;

    uutp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_char   (r_in_char),
        .o_term   (w_term),
        .o_result (w_result)
    );

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && (!w_term || w_out_free);
    assign w_emit          = w_step && w_term;
    assign o_s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
        end
        if (w_emit) begin
            r_out_res <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, r_out_res};

    `UUTP_ASSERT_IMP(a_emit_room, i_clk, i_rst_n,
        w_emit, w_out_free, "result overwrites an untaken transaction")
    `UUTP_ASSERT_NXT(a_held_stall, i_clk, i_rst_n,
        r_in_valid && !w_step, r_in_valid && $stable(r_in_char),
        "pending character lost while stalled")
    `UUTP_ASSERT_IMP(a_stall_only_term, i_clk, i_rst_n,
        r_in_valid && !w_step, w_term && r_out_valid && !i_m_axis_tready,
        "character stalled without a blocked terminator")

endmodule
